@@ hw/rtl/quadrature_decoder_angle_core_assert.svh @@
// Assertion macros shared by the quadrature decoder RTL.
`ifndef QUADRATURE_DECODER_ANGLE_CORE_ASSERT_SVH
`define QUADRATURE_DECODER_ANGLE_CORE_ASSERT_SVH

// Same-cycle implication, clocked by i_clk, off during reset.
`define QDEC_AST_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("qdec assertion failed");

// Next-cycle implication, clocked by i_clk, off during reset.
`define QDEC_AST_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("qdec assertion failed");

`endif

@@ hw/rtl/qdec_pkg.sv @@
// Types and constants of the quadrature decoder.
`default_nettype none

package qdec_pkg;

    // Width of the pulse, index and turn counters
    localparam int COUNT_WIDTH = 32;
    localparam int OUT_CNT_W   = 32;
    localparam int POS_W       = 19;
    localparam int CPT_W       = 18;
    localparam int DPC_W       = 23;
    localparam int TANG_W      = 26;
    localparam int AANG_W      = 56;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 23;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 200;

    // Reset values of the configuration registers
    localparam logic [CPT_W-1:0] CPT_RESET = CPT_W'(2048);
    localparam logic [DPC_W-1:0] DPC_RESET = DPC_W'(11520);

    // Widest legal within-turn count
    localparam logic signed [POS_W-1:0] TPOS_MAX = POS_W'(262140);

    // Command codes
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_LOAD   = 2'd2
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECODE_MODE = 2'd0,
        CFG_CPT         = 2'd1,
        CFG_DPC         = 2'd2,
        CFG_ENABLE      = 2'd3
    } t_cfg_idx;

    // Decode mode values
    localparam logic MODE_X2 = 1'b0;
    localparam logic MODE_X4 = 1'b1;

    typedef struct packed {
        logic signed [31:0] load_revs;
        logic signed [31:0] load_pulses;
        logic               index_level;
        logic               chan_b;
        logic               chan_a;
        logic [1:0]         op;
    } t_in_item;

    typedef struct packed {
        logic             decode_mode;
        logic [CPT_W-1:0] counts_per_turn;
        logic [DPC_W-1:0] degrees_per_count;
        logic             decode_enable;
    } t_cfg;

    typedef struct packed {
        logic signed [COUNT_WIDTH-1:0] pulse_total;
        logic signed [COUNT_WIDTH-1:0] index_total;
        logic signed [COUNT_WIDTH-1:0] turn_total;
        logic signed [POS_W-1:0]       turn_counts;
        logic [1:0]                    last_ab;
    } t_state;

    typedef struct packed {
        logic [1:0]                  ab_state;
        logic signed [AANG_W-1:0]    total_angle_q16;
        logic signed [TANG_W-1:0]    turn_angle_q16;
        logic signed [POS_W-1:0]     turn_position;
        logic signed [OUT_CNT_W-1:0] turns;
        logic signed [OUT_CNT_W-1:0] index_revs;
        logic signed [OUT_CNT_W-1:0] pulse_count;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/qdec_decode.sv @@
// Decode stage: holds the counter state and applies one command per advance.
`default_nettype none

module qdec_decode (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire qdec_pkg::t_in_item i_item,
    input  wire qdec_pkg::t_cfg    i_cfg,
    output qdec_pkg::t_state       o_state
);
    import qdec_pkg::*;

    t_state r_st, n_st;
    logic   r_last_index, n_last_index;
    logic   r_primed, n_primed;

    logic [1:0]              cur_ab;
    logic [1:0]              prev_ab;
    logic                    eval;
    logic                    step_up;
    logic                    step_dn;
    logic signed [POS_W:0]   tc_step;
    logic signed [POS_W:0]   lim;
    logic                    pos_ok;
    logic                    adv_clear;
    logic                    adv_prime;

    // A/B transition rules
    always_comb begin
        cur_ab  = {i_item.chan_a, i_item.chan_b};
        prev_ab = r_st.last_ab;
        eval    = 1'b0;
        step_up = 1'b0;
        step_dn = 1'b0;
        if (i_cfg.decode_mode == MODE_X2) begin
            if (prev_ab[1] != cur_ab[1]) begin
                eval    = 1'b1;
                step_up = (prev_ab == 2'd3 && cur_ab == 2'd0) ||
                          (prev_ab == 2'd0 && cur_ab == 2'd3);
                step_dn = (prev_ab == 2'd2 && cur_ab == 2'd1) ||
                          (prev_ab == 2'd1 && cur_ab == 2'd2);
            end
        end else begin
            if (prev_ab != cur_ab) begin
                eval = 1'b1;
                if ((prev_ab ^ cur_ab) != 2'd3) begin
                    step_dn = prev_ab[0] ^ cur_ab[1];
                    step_up = ~(prev_ab[0] ^ cur_ab[1]);
                end
            end
        end
    end

    // Within-turn count after the step, and the wrap limit (zero acts as one)
    always_comb begin
        tc_step = (POS_W+1)'(r_st.turn_counts);
        if (step_up) begin
            tc_step = tc_step + (POS_W+1)'(1);
        end else if (step_dn) begin
            tc_step = tc_step - (POS_W+1)'(1);
        end
        lim = (i_cfg.counts_per_turn == '0) ? (POS_W+1)'(1)
                                            : (POS_W+1)'(i_cfg.counts_per_turn);
    end

    // Next state per command
    always_comb begin
        n_st         = r_st;
        n_last_index = r_last_index;
        n_primed     = r_primed;
        case (i_item.op)
            OP_SAMPLE: begin
                if (!r_primed) begin
                    n_st.last_ab = cur_ab;
                    n_last_index = i_item.index_level;
                    n_primed     = 1'b1;
                end else begin
                    if (!r_last_index && i_item.index_level) begin
                        n_st.index_total = r_st.index_total + COUNT_WIDTH'(1);
                    end
                    n_last_index = i_item.index_level;
                    if (i_cfg.decode_enable && eval) begin
                        if (step_up) begin
                            n_st.pulse_total = r_st.pulse_total + COUNT_WIDTH'(1);
                        end else if (step_dn) begin
                            n_st.pulse_total = r_st.pulse_total - COUNT_WIDTH'(1);
                        end
                        if (tc_step >= lim) begin
                            n_st.turn_counts = '0;
                            n_st.turn_total  = r_st.turn_total + COUNT_WIDTH'(1);
                        end else if (tc_step <= -lim) begin
                            n_st.turn_counts = '0;
                            n_st.turn_total  = r_st.turn_total - COUNT_WIDTH'(1);
                        end else begin
                            n_st.turn_counts = POS_W'(tc_step);
                        end
                        n_st.last_ab = cur_ab;
                    end
                end
            end
            OP_CLEAR: begin
                n_st.pulse_total = '0;
                n_st.index_total = '0;
                n_st.turn_total  = '0;
                n_st.turn_counts = '0;
            end
            OP_LOAD: begin
                n_st.pulse_total = COUNT_WIDTH'(i_item.load_pulses);
                n_st.index_total = COUNT_WIDTH'(i_item.load_revs);
            end
            default: begin
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= '0;
            r_last_index <= 1'b0;
            r_primed     <= 1'b0;
        end else if (i_adv) begin
            r_st         <= n_st;
            r_last_index <= n_last_index;
            r_primed     <= n_primed;
        end
    end

    assign o_state = r_st;

    // assertion terms
    assign pos_ok    = (r_st.turn_counts <= TPOS_MAX) && (r_st.turn_counts >= -TPOS_MAX);
    assign adv_clear = i_adv && (i_item.op == OP_CLEAR);
    assign adv_prime = i_adv && !r_primed && (i_item.op == OP_SAMPLE);

    `include "quadrature_decoder_angle_core_assert.svh"

    // within-turn count never leaves the widest legal turn
    `QDEC_AST_IMP(a_pos_range, 1'b1, pos_ok)
    // a clear command zeroes all counters
    `QDEC_AST_NXT(a_clear, adv_clear, r_st.pulse_total == '0 && r_st.turn_counts == '0)
    // nothing is counted before the first sample primes the history
    `QDEC_AST_NXT(a_prime, adv_prime, $stable(r_st.pulse_total) && r_primed)

endmodule

`default_nettype wire

@@ hw/rtl/qdec_angle.sv @@
// Angle stage: multiplies the counts into Q16 degrees and holds the result word.
`default_nettype none

module qdec_angle (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_vld,
    input  wire qdec_pkg::t_state            i_state,
    input  wire logic [qdec_pkg::DPC_W-1:0]  i_dpc,
    output logic                             o_vld,
    output qdec_pkg::t_result                o_res
);
    import qdec_pkg::*;

    logic                        r_vld;
    t_result                     r_res, n_res;
    logic signed [DPC_W:0]       dpc_s;
    logic signed [AANG_W-1:0]    total_prod;
    logic signed [POS_W+DPC_W:0] turn_prod;

    // one multiply per product, both in parallel
    always_comb begin
        dpc_s       = $signed({1'b0, i_dpc});
        total_prod  = AANG_W'(i_state.pulse_total) * AANG_W'(dpc_s);
        turn_prod   = (POS_W+DPC_W+1)'(i_state.turn_counts) * (POS_W+DPC_W+1)'(dpc_s);

        n_res.pulse_count     = OUT_CNT_W'(i_state.pulse_total);
        n_res.index_revs      = OUT_CNT_W'(i_state.index_total);
        n_res.turns           = OUT_CNT_W'(i_state.turn_total);
        n_res.turn_position   = i_state.turn_counts;
        n_res.turn_angle_q16  = turn_prod[TANG_W-1:0];
        n_res.total_angle_q16 = total_prod;
        n_res.ab_state        = i_state.last_ab;
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_vld) begin
            r_res <= n_res;
        end
    end

    assign o_vld = r_vld;
    assign o_res = r_res;

endmodule

`default_nettype wire

@@ hw/rtl/quadrature_decoder_angle_core.sv @@
// Top level of the quadrature decoder with turn and angle tracking.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser=op, tdata=pins and load values
//  m_axis    out  tvalid/tready          tdata=counts, angles, A/B state
//  cfg       in   i_cfg_we (no stall)    i_cfg_idx, i_cfg_data
//
// One word per cycle while m_axis is ready; an accepted word passes through the input
// register, the decode stage holding the counters and the multiply stage into the output
// register before its result word is valid.
// The counters update when a word leaves the input register for the decode stage.
// Synchronous active-low reset clears the counters and reloads register defaults.
// A stalled m_axis backs up through the stages; empty stages keep accepting.
`default_nettype none

module quadrature_decoder_angle_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // op[1:0]
    input  wire logic [1:0]                         s_axis_tuser,
    // chan_a, chan_b, index_level, load_pulses[31:0], load_revs[31:0], zero pad
    input  wire logic [qdec_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // pulse_count, index_revs, turns, turn_position[18:0], turn_angle_q16[25:0],
    // total_angle_q16[55:0], ab_state[1:0], zero pad
    output logic [qdec_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic                               i_cfg_we,
    input  wire logic [qdec_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [qdec_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import qdec_pkg::*;

    t_cfg     r_cfg;
    t_in_item r_in, n_in;
    logic     r_in_vld;
    logic     r_mid_vld;
    logic     in_en;
    logic     mid_en;
    logic     out_en;
    logic     out_vld;
    t_state   state;
    t_result  res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decode_mode       <= MODE_X2;
            r_cfg.counts_per_turn   <= CPT_RESET;
            r_cfg.degrees_per_count <= DPC_RESET;
            r_cfg.decode_enable     <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DECODE_MODE: r_cfg.decode_mode       <= i_cfg_data[0];
                CFG_CPT:         r_cfg.counts_per_turn   <= i_cfg_data[CPT_W-1:0];
                CFG_DPC:         r_cfg.degrees_per_count <= i_cfg_data[DPC_W-1:0];
                CFG_ENABLE:      r_cfg.decode_enable     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // stage enables: a stage moves when it is empty or the next one moves
    assign out_en        = !out_vld || m_axis_tready;
    assign mid_en        = !r_mid_vld || out_en;
    assign in_en         = !r_in_vld || mid_en;
    assign s_axis_tready = in_en;

    // unpack the input word
    always_comb begin
        n_in.op          = s_axis_tuser;
        n_in.chan_a      = s_axis_tdata[0];
        n_in.chan_b      = s_axis_tdata[1];
        n_in.index_level = s_axis_tdata[2];
        n_in.load_pulses = s_axis_tdata[34:3];
        n_in.load_revs   = s_axis_tdata[66:35];
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_mid_vld <= 1'b0;
        end else begin
            if (in_en) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (mid_en) begin
                r_mid_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_en && s_axis_tvalid) begin
            r_in <= n_in;
        end
    end

    qdec_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (mid_en && r_in_vld),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_state (state)
    );

    qdec_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (out_en),
        .i_vld   (r_mid_vld),
        .i_state (state),
        .i_dpc   (r_cfg.degrees_per_count),
        .o_vld   (out_vld),
        .o_res   (res)
    );

    // pack the output word
    assign m_axis_tvalid = out_vld;
    assign m_axis_tdata  = {1'b0, res.ab_state, res.total_angle_q16, res.turn_angle_q16,
                            res.turn_position, res.turns, res.index_revs, res.pulse_count};

    `include "quadrature_decoder_angle_core_assert.svh"

    // a decoded word always moves into an empty output register
    `QDEC_AST_NXT(a_mid_drain, r_mid_vld && !out_vld, out_vld)
    // an empty pipeline always takes a word
    `QDEC_AST_IMP(a_empty_ready, !r_in_vld && !r_mid_vld && !out_vld, s_axis_tready)
    // an accepted word is held in the input register next cycle
    `QDEC_AST_NXT(a_in_capture, s_axis_tvalid && s_axis_tready, r_in_vld)

endmodule

`default_nettype wire

@@ test/tb_quadrature_decoder_angle_core.sv @@
// Self-checking testbench for the quadrature decoder with turn and angle tracking.
`timescale 1ns / 100ps

module tb_quadrature_decoder_angle_core;
    import qdec_pkg::*;

    // Command code that the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          N_PHASES        = 8;
    localparam int          WORDS_PER_PHASE = 80;
    localparam int          HOLD_AT         = 300;
    localparam int          HOLD_CYCLES     = 200;
    localparam int          PIPE_DEPTH      = 3;
    localparam int          MAX_REPORTS     = 40;

    // Forward walk through the A/B Gray sequence
    localparam logic [1:0]  GRAY_SEQ [4] = '{2'd0, 2'd1, 2'd3, 2'd2};
    localparam logic [31:0] LOAD_EXTREMES [4] =
        '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff};

    typedef enum logic {ROW_WORD, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  op;
        logic        a;
        logic        b;
        logic        idx;
        logic [31:0] lp;
        logic [31:0] lr;
        bit          known;
        logic [31:0] want_pulses;
        logic [31:0] want_revs;
        t_cfg_idx    reg_idx;
        logic [22:0] reg_val;
    } t_stim_row;

    // DUT signals
    logic                     i_clk;
    logic                     i_rst_n         = 1'b0;
    logic [1:0]               s_axis_tuser    = '0;
    logic [IN_TDATA_W-1:0]    s_axis_tdata    = '0;
    logic                     s_axis_tvalid   = 1'b0;
    logic                     s_axis_tready;
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready   = 1'b0;
    logic                     i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx       = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data      = '0;

    // Decoder mirror: configuration
    logic                     m_mode    = MODE_X2;
    logic [CPT_W-1:0]         m_cpt     = CPT_RESET;
    logic [DPC_W-1:0]         m_dpc     = DPC_RESET;
    logic                     m_enable  = 1'b1;

    // Decoder mirror: state
    logic [1:0]               m_last_ab  = '0;
    logic                     m_last_idx = 1'b0;
    bit                       m_primed   = 1'b0;
    logic [31:0]              m_pulse_tot = '0;
    logic [31:0]              m_index_tot = '0;
    logic [31:0]              m_turn_tot  = '0;
    int                       m_turn_cnt  = 0;

    t_result                  pending_results[$];
    t_stim_row                directed[$];
    int unsigned              n_words_in    = 0;
    int unsigned              n_results_out = 0;
    int unsigned              n_errors      = 0;
    int unsigned              n_turn_wraps  = 0;
    int unsigned              n_index_edges = 0;
    int unsigned              n_cycles      = 0;
    bit                       tx_burst      = 1'b0;
    bit                       rx_burst      = 1'b0;
    logic [1:0]               walk_pos      = '0;
    logic                     walk_idx      = 1'b0;

    quadrature_decoder_angle_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     n_cycles, pending_results.size());
            $display("quadrature_decoder_angle_core regression: fail");
            $finish;
        end
    end

    // A/B evaluation of one sample, with the within-turn wrap
    function automatic void decode_pins(logic [1:0] cur);
        logic [1:0] prev;
        int         dir;
        int         lim;
        prev = m_last_ab;
        dir  = 0;
        if (m_mode == MODE_X2) begin
            if (prev[1] == cur[1])
                return;
            if ((prev == 2'd3 && cur == 2'd0) || (prev == 2'd0 && cur == 2'd3))
                dir = 1;
            else if ((prev == 2'd2 && cur == 2'd1) || (prev == 2'd1 && cur == 2'd2))
                dir = -1;
        end else begin
            if (cur == prev)
                return;
            // double-bit jumps carry no direction
            if ((cur ^ prev) != 2'd3)
                dir = (prev[0] ^ cur[1]) ? -1 : 1;
        end
        m_pulse_tot = m_pulse_tot + 32'(dir);
        m_turn_cnt  = m_turn_cnt + dir;
        lim = (m_cpt == '0) ? 1 : int'(m_cpt);
        if (m_turn_cnt >= lim) begin
            m_turn_cnt = 0;
            m_turn_tot = m_turn_tot + 32'd1;
            n_turn_wraps++;
        end else if (m_turn_cnt <= -lim) begin
            m_turn_cnt = 0;
            m_turn_tot = m_turn_tot - 32'd1;
            n_turn_wraps++;
        end
        m_last_ab = cur;
    endfunction

    // Advance the mirror by one command word and return the result it yields
    function automatic t_result track_encoder(logic [1:0] op, logic a, logic b, logic idx,
                                               logic [31:0] lp, logic [31:0] lr);
        t_result r;
        longint  dpc_l;
        longint  tc_l;
        longint  pulse_l;
        case (op)
            OP_SAMPLE: begin
                if (!m_primed) begin
                    m_last_ab  = {a, b};
                    m_last_idx = idx;
                    m_primed   = 1'b1;
                end else begin
                    if (!m_last_idx && idx) begin
                        m_index_tot = m_index_tot + 32'd1;
                        n_index_edges++;
                    end
                    m_last_idx = idx;
                    if (m_enable)
                        decode_pins({a, b});
                end
            end
            OP_CLEAR: begin
                m_pulse_tot = '0;
                m_index_tot = '0;
                m_turn_tot  = '0;
                m_turn_cnt  = 0;
            end
            OP_LOAD: begin
                m_pulse_tot = lp;
                m_index_tot = lr;
            end
            default: ;
        endcase
        dpc_l   = longint'(m_dpc);
        tc_l    = longint'(m_turn_cnt);
        pulse_l = longint'(signed'(m_pulse_tot));
        r.pulse_count     = m_pulse_tot;
        r.index_revs      = m_index_tot;
        r.turns           = m_turn_tot;
        r.turn_position   = m_turn_cnt[POS_W-1:0];
        r.turn_angle_q16  = TANG_W'(tc_l * dpc_l);
        r.total_angle_q16 = AANG_W'(pulse_l * dpc_l);
        r.ab_state        = m_last_ab;
        return r;
    endfunction

    function automatic void compare_field(string fname, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                         $time, fname, want, got);
        end
    endfunction

    // Table row builders
    function automatic t_stim_row word_row(logic [1:0] op, logic a, logic b, logic idx,
                                           logic [31:0] lp, logic [31:0] lr);
        t_stim_row row;
        row.kind        = ROW_WORD;
        row.op          = op;
        row.a           = a;
        row.b           = b;
        row.idx         = idx;
        row.lp          = lp;
        row.lr          = lr;
        row.known       = 1'b0;
        row.want_pulses = '0;
        row.want_revs   = '0;
        row.reg_idx     = CFG_DECODE_MODE;
        row.reg_val     = '0;
        return row;
    endfunction

    function automatic t_stim_row known_row(logic [1:0] op, logic a, logic b, logic idx,
                                            logic [31:0] lp, logic [31:0] lr,
                                            logic [31:0] want_p, logic [31:0] want_r);
        t_stim_row row;
        row             = word_row(op, a, b, idx, lp, lr);
        row.known       = 1'b1;
        row.want_pulses = want_p;
        row.want_revs   = want_r;
        return row;
    endfunction

    function automatic t_stim_row reg_row(t_cfg_idx ridx, logic [22:0] val);
        t_stim_row row;
        row         = word_row(OP_SAMPLE, 1'b0, 1'b0, 1'b0, '0, '0);
        row.kind    = ROW_REG;
        row.reg_idx = ridx;
        row.reg_val = val;
        return row;
    endfunction

    // Register write, only once the pipeline has drained
    task automatic write_reg(t_cfg_idx ridx, logic [22:0] val);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DEPTH) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ridx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (ridx)
            CFG_DECODE_MODE: m_mode   = val[0];
            CFG_CPT:         m_cpt    = val[CPT_W-1:0];
            CFG_DPC:         m_dpc    = val[DPC_W-1:0];
            CFG_ENABLE:      m_enable = val[0];
            default: ;
        endcase
    endtask

    // Offer one command word and record what it should produce
    task automatic send_word(logic [1:0] op, logic a, logic b, logic idx,
                             logic [31:0] lp, logic [31:0] lr,
                             bit known, logic [31:0] want_p, logic [31:0] want_r);
        int unsigned gap;
        t_result     want;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'd0, lr, lp, idx, b, a};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        want = track_encoder(op, a, b, idx, lp, lr);
        if (known) begin
            want.pulse_count = want_p;
            want.index_revs  = want_r;
        end
        pending_results.push_back(want);
        n_words_in++;
    endtask

    // Mostly Gray-code steps with a direction bias; some holds, jumps and commands
    task automatic send_random_word(int unsigned fwd_pct);
        int unsigned pick;
        logic [1:0]  op;
        logic [31:0] lp;
        logic [31:0] lr;
        logic [1:0]  ab;
        pick = $urandom_range(0, 99);
        lp   = $urandom;
        lr   = $urandom;
        op   = OP_SAMPLE;
        if (pick < 3) begin
            op = OP_CLEAR;
        end else if (pick < 7) begin
            op = OP_LOAD;
            if ($urandom_range(0, 2) == 0)
                lp = LOAD_EXTREMES[$urandom_range(0, 3)];
            if ($urandom_range(0, 2) == 0)
                lr = LOAD_EXTREMES[$urandom_range(0, 3)];
        end else if (pick < 9) begin
            op = OP_UNUSED;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                ;
            else if (pick < 13)
                walk_pos = walk_pos + 2'd2;
            else if (pick < 13 + (fwd_pct * 87) / 100)
                walk_pos = walk_pos + 2'd1;
            else
                walk_pos = walk_pos + 2'd3;
            if ($urandom_range(0, 5) == 0)
                walk_idx = ~walk_idx;
        end
        ab = GRAY_SEQ[walk_pos];
        send_word(op, ab[1], ab[0], walk_idx, lp, lr, 1'b0, '0, '0);
    endtask

    // Result side: random stalls, one long hold, field-by-field compare
    initial begin : result_sink
        t_result     got;
        t_result     want;
        int unsigned stall;
        bit          held;
        held = 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (!held && n_results_out >= HOLD_AT) begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end else if (rx_burst) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 9);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            got = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
            n_results_out++;
            if (n_results_out % 64 == 0)
                rx_burst = ($urandom_range(0, 2) == 0);
            if (pending_results.size() == 0) begin
                n_errors++;
                $display("%0t ns: result word with nothing expected, actual %h",
                         $time, m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                compare_field("pulse_count", 64'(want.pulse_count), 64'(got.pulse_count));
                compare_field("index_revs", 64'(want.index_revs), 64'(got.index_revs));
                compare_field("turns", 64'(want.turns), 64'(got.turns));
                compare_field("turn_position", 64'(want.turn_position),
                              64'(got.turn_position));
                compare_field("turn_angle_q16", 64'(want.turn_angle_q16),
                              64'(got.turn_angle_q16));
                compare_field("total_angle_q16", 64'(want.total_angle_q16),
                              64'(got.total_angle_q16));
                compare_field("ab_state", 64'(want.ab_state), 64'(got.ab_state));
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        int          ph;
        logic [22:0] cpt_val;
        logic [22:0] dpc_val;

        // X2 decoding at reset settings, counter extremes, clear and unused command
        directed.push_back(known_row(OP_SAMPLE, 1'b0, 1'b0, 1'b0, '0, '0, 32'd0, 32'd0));
        directed.push_back(known_row(OP_SAMPLE, 1'b1, 1'b1, 1'b1, '0, '0, 32'd1, 32'd1));
        directed.push_back(known_row(OP_SAMPLE, 1'b0, 1'b0, 1'b0, '0, '0, 32'd2, 32'd1));
        // only B moves: ignored in X2
        directed.push_back(known_row(OP_SAMPLE, 1'b0, 1'b1, 1'b0, '0, '0, 32'd2, 32'd1));
        directed.push_back(known_row(OP_SAMPLE, 1'b1, 1'b0, 1'b0, '0, '0, 32'd2, 32'd1));
        directed.push_back(known_row(OP_SAMPLE, 1'b0, 1'b1, 1'b0, '0, '0, 32'd1, 32'd1));
        directed.push_back(known_row(OP_LOAD, 1'b0, 1'b0, 1'b0, 32'h7fff_ffff, 32'h8000_0000,
                                     32'h7fff_ffff, 32'h8000_0000));
        directed.push_back(known_row(OP_SAMPLE, 1'b1, 1'b0, 1'b1, '0, '0,
                                     32'h7fff_fffe, 32'h8000_0001));
        directed.push_back(known_row(OP_SAMPLE, 1'b0, 1'b1, 1'b0, '0, '0,
                                     32'h7fff_fffd, 32'h8000_0001));
        directed.push_back(known_row(OP_LOAD, 1'b0, 1'b1, 1'b0, 32'h8000_0000, 32'hffff_ffff,
                                     32'h8000_0000, 32'hffff_ffff));
        // both counters wrap through their extremes
        directed.push_back(known_row(OP_SAMPLE, 1'b1, 1'b0, 1'b1, '0, '0,
                                     32'h7fff_ffff, 32'd0));
        directed.push_back(known_row(OP_UNUSED, 1'b0, 1'b0, 1'b0, 32'h1234_5678,
                                     32'h9abc_def0, 32'h7fff_ffff, 32'd0));
        directed.push_back(known_row(OP_CLEAR, 1'b0, 1'b0, 1'b0, '0, '0, 32'd0, 32'd0));
        // X4 with the smallest turn and the largest angle step
        directed.push_back(reg_row(CFG_DECODE_MODE, 23'(MODE_X4)));
        directed.push_back(reg_row(CFG_CPT, 23'd4));
        directed.push_back(reg_row(CFG_DPC, 23'd5898240));
        directed.push_back(word_row(OP_SAMPLE, 1'b1, 1'b1, 1'b0, '0, '0));
        directed.push_back(word_row(OP_SAMPLE, 1'b0, 1'b1, 1'b0, '0, '0));
        directed.push_back(word_row(OP_SAMPLE, 1'b0, 1'b0, 1'b0, '0, '0));
        directed.push_back(word_row(OP_SAMPLE, 1'b1, 1'b0, 1'b0, '0, '0));
        // double-bit jump
        directed.push_back(word_row(OP_SAMPLE, 1'b0, 1'b1, 1'b0, '0, '0));
        directed.push_back(word_row(OP_SAMPLE, 1'b1, 1'b1, 1'b0, '0, '0));
        directed.push_back(word_row(OP_SAMPLE, 1'b1, 1'b0, 1'b0, '0, '0));
        directed.push_back(word_row(OP_SAMPLE, 1'b0, 1'b0, 1'b0, '0, '0));
        directed.push_back(word_row(OP_SAMPLE, 1'b0, 1'b1, 1'b0, '0, '0));
        directed.push_back(word_row(OP_SAMPLE, 1'b0, 1'b1, 1'b0, '0, '0));
        // decoding frozen, index still counted; largest turn, smallest angle step
        directed.push_back(reg_row(CFG_CPT, 23'd262140));
        directed.push_back(reg_row(CFG_DPC, 23'd1));
        directed.push_back(reg_row(CFG_ENABLE, 23'd0));
        directed.push_back(word_row(OP_SAMPLE, 1'b1, 1'b0, 1'b1, '0, '0));
        directed.push_back(word_row(OP_SAMPLE, 1'b0, 1'b0, 1'b0, '0, '0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            if (directed[k].kind == ROW_REG)
                write_reg(directed[k].reg_idx, directed[k].reg_val);
            else
                send_word(directed[k].op, directed[k].a, directed[k].b, directed[k].idx,
                          directed[k].lp, directed[k].lr, directed[k].known,
                          directed[k].want_pulses, directed[k].want_revs);
        end

        // Random phases, each under its own settings
        for (ph = 0; ph < N_PHASES; ph++) begin
            if (ph == 1) begin
                cpt_val = '0;   // zero limit acts as one
            end else begin
                case ($urandom_range(0, 4))
                    0:       cpt_val = 23'd4;
                    1:       cpt_val = 23'd262140;
                    2, 3:    cpt_val = 23'($urandom_range(5, 40));
                    default: cpt_val = 23'($urandom_range(4, 262140));
                endcase
            end
            case ($urandom_range(0, 3))
                0:       dpc_val = 23'd1;
                1:       dpc_val = 23'd5898240;
                default: dpc_val = 23'($urandom_range(1, 5898240));
            endcase
            write_reg(CFG_DECODE_MODE, 23'($urandom_range(0, 1)));
            write_reg(CFG_CPT, cpt_val);
            write_reg(CFG_DPC, dpc_val);
            write_reg(CFG_ENABLE, 23'($urandom_range(0, 5) != 0));
            tx_burst = (ph % 3 == 2);
            repeat (WORDS_PER_PHASE) send_random_word($urandom_range(20, 80));
        end

        // Drain
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4 * PIPE_DEPTH) @(posedge i_clk);

        $display("sent %0d command words, checked %0d results over %0d setting phases",
                 n_words_in, n_results_out, N_PHASES + 1);
        $display("saw %0d turn wraps and %0d index edges, %0d mismatches",
                 n_turn_wraps, n_index_edges, n_errors);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("quadrature_decoder_angle_core regression: pass");
        else
            $display("quadrature_decoder_angle_core regression: fail");
        $finish;
    end

endmodule
